// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL files that check themselves.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted.
`define KCC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, also checked across reset.
`define KCC_ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/kcc_pkg.sv =====
// Shared types and constants of the key click classifier.
package kcc_pkg;

    localparam int NUM_KEYS   = 4;
    localparam int TIMER_BITS = 16;
    localparam int PIN_BITS   = 4;
    localparam int KEY_W      = 2;
    localparam int CMP_BITS   = (TIMER_BITS > 16) ? TIMER_BITS : 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SHORT  = 2'd1,
        EV_LONG   = 2'd2,
        EV_DOUBLE = 2'd3
    } kcc_event_t;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LEVEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEB_SAMPLES  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEB_TIMEOUT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DBL_WINDOW   = 3'd4;

    typedef struct packed {
        logic        active_level;
        logic [7:0]  debounce_samples;
        logic [15:0] debounce_timeout;
        logic [15:0] long_press_ticks;
        logic [15:0] double_click_window;
    } kcc_cfg_t;

    localparam kcc_cfg_t CFG_RESET = '{
        active_level:        1'b0,
        debounce_samples:    8'd20,
        debounce_timeout:    16'd100,
        long_press_ticks:    16'd1000,
        double_click_window: 16'd300
    };

    // Event latch of one lane, before and after the current word
    typedef struct packed {
        kcc_event_t latch_cur;
        kcc_event_t latch_next;
    } kcc_lane_stat_t;

    // Output buffer status seen by the top level
    typedef struct packed {
        logic                main_valid;
        logic                skid_valid;
        logic [PIN_BITS-1:0] item_mask;
    } kcc_merge_stat_t;

endpackage

// ===== design/kcc_lane.sv =====
// One key's debounce and click classification machine with its event latch.
module kcc_lane (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    tick,
    input  logic                    clr,
    input  logic                    pin_sample,
    input  kcc_pkg::kcc_cfg_t       cfg,
    output kcc_pkg::kcc_lane_stat_t stat
);

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_DEB_PRESS = 3'd1,
        PH_PRESSED   = 3'd2,
        PH_DEB_REL   = 3'd3,
        PH_WAIT_DBL  = 3'd4
    } phase_t;

    localparam logic [kcc_pkg::TIMER_BITS-1:0] TIMER_MAX = '1;

    phase_t                          phase_reg, phase_next;
    logic [kcc_pkg::TIMER_BITS-1:0]  timer_reg, timer_next;
    logic [7:0]                      agree_reg, agree_next;
    logic                            long_rep_reg, long_rep_next;
    logic                            second_reg, second_next;
    kcc_pkg::kcc_event_t             latch_reg, latch_next;

    logic                            pressed;
    logic [kcc_pkg::TIMER_BITS-1:0]  t_inc;
    logic [7:0]                      a_inc;
    logic [kcc_pkg::CMP_BITS-1:0]    t_inc_x;
    logic                            agree_ok;
    logic                            tmo_hit;
    logic                            long_hit;
    logic                            dbl_hit;

    assign pressed  = (pin_sample == cfg.active_level);
    assign t_inc    = (timer_reg == TIMER_MAX) ? timer_reg : timer_reg + 1'b1;
    assign a_inc    = (agree_reg == 8'hFF) ? agree_reg : agree_reg + 8'd1;
    assign t_inc_x  = kcc_pkg::CMP_BITS'(t_inc);
    assign agree_ok = (a_inc >= cfg.debounce_samples);
    assign tmo_hit  = (t_inc_x >= kcc_pkg::CMP_BITS'(cfg.debounce_timeout));
    assign long_hit = (t_inc_x >= kcc_pkg::CMP_BITS'(cfg.long_press_ticks));
    assign dbl_hit  = (t_inc_x >= kcc_pkg::CMP_BITS'(cfg.double_click_window));

    always_comb begin
        phase_next    = phase_reg;
        timer_next    = timer_reg;
        agree_next    = agree_reg;
        long_rep_next = long_rep_reg;
        second_next   = second_reg;
        latch_next    = latch_reg;
        if (clr) begin
            latch_next = kcc_pkg::EV_NONE;
        end
        if (tick) begin
            unique case (phase_reg)
                PH_IDLE: begin
                    if (pressed) begin
                        agree_next    = '0;
                        timer_next    = '0;
                        second_next   = 1'b0;
                        long_rep_next = 1'b0;
                        phase_next    = PH_DEB_PRESS;
                    end
                end
                PH_DEB_PRESS: begin
                    timer_next = t_inc;
                    agree_next = pressed ? a_inc : 8'd0;
                    if (pressed && agree_ok) begin
                        phase_next = PH_PRESSED;
                        timer_next = '0;
                    end else if (tmo_hit) begin
                        if (second_reg) begin
                            latch_next  = kcc_pkg::EV_SHORT;
                            second_next = 1'b0;
                        end
                        phase_next = PH_IDLE;
                    end
                end
                PH_PRESSED: begin
                    if (pressed) begin
                        // hold the timer on a second click: no long press there
                        if (!second_reg) begin
                            timer_next = t_inc;
                            if (long_hit && !long_rep_reg) begin
                                latch_next    = kcc_pkg::EV_LONG;
                                long_rep_next = 1'b1;
                            end
                        end
                    end else begin
                        agree_next = '0;
                        timer_next = '0;
                        phase_next = PH_DEB_REL;
                    end
                end
                PH_DEB_REL: begin
                    timer_next = t_inc;
                    agree_next = pressed ? 8'd0 : a_inc;
                    if (!pressed && agree_ok) begin
                        if (second_reg) begin
                            latch_next  = kcc_pkg::EV_DOUBLE;
                            second_next = 1'b0;
                            phase_next  = PH_IDLE;
                        end else if (long_rep_reg) begin
                            phase_next = PH_IDLE;
                        end else begin
                            phase_next = PH_WAIT_DBL;
                            timer_next = '0;
                        end
                    end else if (tmo_hit) begin
                        if (second_reg) begin
                            latch_next  = kcc_pkg::EV_DOUBLE;
                            second_next = 1'b0;
                        end else if (!long_rep_reg) begin
                            latch_next = kcc_pkg::EV_SHORT;
                        end
                        phase_next = PH_IDLE;
                    end
                end
                PH_WAIT_DBL: begin
                    if (pressed) begin
                        agree_next  = '0;
                        timer_next  = '0;
                        second_next = 1'b1;
                        phase_next  = PH_DEB_PRESS;
                    end else begin
                        timer_next = t_inc;
                        if (dbl_hit) begin
                            latch_next = kcc_pkg::EV_SHORT;
                            phase_next = PH_IDLE;
                        end
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            timer_reg    <= '0;
            agree_reg    <= '0;
            long_rep_reg <= 1'b0;
            second_reg   <= 1'b0;
            latch_reg    <= kcc_pkg::EV_NONE;
        end else begin
            phase_reg    <= phase_next;
            timer_reg    <= timer_next;
            agree_reg    <= agree_next;
            long_rep_reg <= long_rep_next;
            second_reg   <= second_next;
            latch_reg    <= latch_next;
        end
    end

    assign stat.latch_cur  = latch_reg;
    assign stat.latch_next = latch_next;

endmodule

// ===== design/kcc_merge.sv =====
// Combines the lane latches into one result word and buffers it for the output.
module kcc_merge (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_fire,
    input  logic                    is_read,
    input  logic [kcc_pkg::KEY_W-1:0] read_key,
    input  kcc_pkg::kcc_lane_stat_t lane_stat [kcc_pkg::NUM_KEYS],
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [7:0]              m_tdata,
    output kcc_pkg::kcc_merge_stat_t stat
);

    localparam int MASK_KEYS = (kcc_pkg::NUM_KEYS < kcc_pkg::PIN_BITS) ?
                               kcc_pkg::NUM_KEYS : kcc_pkg::PIN_BITS;

    kcc_pkg::kcc_event_t          item_event;
    logic [kcc_pkg::PIN_BITS-1:0] item_mask;
    logic [7:0]                   item_word;

    logic       main_valid_reg, main_valid_next;
    logic       skid_valid_reg, skid_valid_next;
    logic [7:0] main_data_reg, main_data_next;
    logic [7:0] skid_data_reg, skid_data_next;
    logic       out_fire;

    always_comb begin
        item_event = kcc_pkg::EV_NONE;
        item_mask  = '0;
        for (int k = 0; k < kcc_pkg::NUM_KEYS; k++) begin
            if (is_read && (32'(read_key) == k)) begin
                item_event = lane_stat[k].latch_cur;
            end
        end
        for (int k = 0; k < MASK_KEYS; k++) begin
            item_mask[k] = (lane_stat[k].latch_next != kcc_pkg::EV_NONE);
        end
    end

    assign item_word = {2'b00, item_mask, item_event};
    assign out_fire  = main_valid_reg & m_tready;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (out_fire) begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (in_fire) begin
            if (!main_valid_reg || out_fire) begin
                main_data_next  = item_word;
                main_valid_next = 1'b1;
            end else begin
                // output stalled: park the word in the skid stage
                skid_data_next  = item_word;
                skid_valid_next = 1'b1;
            end
        end else if (out_fire) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign s_tready        = ~skid_valid_reg;
    assign m_tvalid        = main_valid_reg;
    assign m_tdata         = main_data_reg;
    assign stat.main_valid = main_valid_reg;
    assign stat.skid_valid = skid_valid_reg;
    assign stat.item_mask  = item_mask;

endmodule

// ===== design/key_click_classifier_unit.sv =====
// Top level of the key click classifier: config registers, key lanes, result merge.
//
// Takes one word per clock while tready is high and gives one result word per input
// word through a registered output with a one-word skid stage; tready stays high
// unless two results are waiting. Every key has its own lane, and all lanes step
// on the same scan word, so the per-key next-state logic (saturating timer and agree
// increments and four threshold compares) sets the clock. A scan word (tuser 0)
// advances every key; a read word (tuser 1) returns the selected key's latched
// event and clears it. Results carry the pending event mask after the word.
`include "assert_macros.svh"

module key_click_classifier_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [kcc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kcc_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [3:0] key pins, [5:4] read_key
    input  logic [0:0]                      s_tuser,   // [0] mode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata    // [1:0] read_event, [5:2] pending_mask
);

    kcc_pkg::kcc_cfg_t            cfg_reg, cfg_next;
    kcc_pkg::kcc_lane_stat_t      lane_stat [kcc_pkg::NUM_KEYS];
    kcc_pkg::kcc_merge_stat_t     merge_stat;
    logic                         in_fire;
    logic                         tick;
    logic                         is_read;
    logic [kcc_pkg::PIN_BITS-1:0] scan_pins;
    logic [kcc_pkg::KEY_W-1:0]    read_key;

    assign scan_pins  = s_tdata[3:0];
    assign read_key   = s_tdata[5:4];
    assign in_fire    = s_tvalid & s_tready;
    assign tick       = in_fire & ~s_tuser[0];
    assign is_read    = in_fire & s_tuser[0];

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                kcc_pkg::CFG_ACTIVE_LEVEL: cfg_next.active_level        = cfg_wdata[0];
                kcc_pkg::CFG_DEB_SAMPLES:  cfg_next.debounce_samples    = cfg_wdata[7:0];
                kcc_pkg::CFG_DEB_TIMEOUT:  cfg_next.debounce_timeout    = cfg_wdata;
                kcc_pkg::CFG_LONG_TICKS:   cfg_next.long_press_ticks    = cfg_wdata;
                kcc_pkg::CFG_DBL_WINDOW:   cfg_next.double_click_window = cfg_wdata;
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= kcc_pkg::CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    for (genvar k = 0; k < kcc_pkg::NUM_KEYS; k++) begin : g_lane
        logic lane_pin;
        logic lane_clr;
        if (k < kcc_pkg::PIN_BITS) begin : g_pin
            assign lane_pin = scan_pins[k];
            assign lane_clr = is_read & (read_key == kcc_pkg::KEY_W'(k));
        end else begin : g_nopin
            // keys without a pin sample low and are never read
            assign lane_pin = 1'b0;
            assign lane_clr = 1'b0;
        end
        kcc_lane u_lane (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .tick       (tick),
            .clr        (lane_clr),
            .pin_sample (lane_pin),
            .cfg        (cfg_reg),
            .stat       (lane_stat[k])
        );
    end

    kcc_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .is_read   (is_read),
        .read_key  (read_key),
        .lane_stat (lane_stat),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .stat      (merge_stat)
    );

    // skid stage only fills behind a full output register
    `KCC_ASSERT_NOW(a_skid_behind_main, aclk, aresetn, merge_stat.skid_valid, merge_stat.main_valid)
    // a read leaves the selected key without a pending event
    `KCC_ASSERT_NOW(a_read_clears, aclk, aresetn, is_read, !merge_stat.item_mask[read_key])
    // reset empties the output buffer
    `KCC_ASSERT_NEXT(a_reset_empty, aclk, !aresetn, !m_tvalid && s_tready)

endmodule
